>>> sv/wmsd_pkg.sv
package wmsd_pkg;

    localparam int WMSD_VALUE_BINS = 256;
    localparam int WMSD_WINDOW_MAX = 1024;

    localparam int IN_TDATA_W  = 8;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 32;
    localparam int OUT_FIELD_W = 2 + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [1:0] t_hist_op;

    localparam t_hist_op OP_CLEAR  = 2'd0;
    localparam t_hist_op OP_SCAN   = 2'd1;
    localparam t_hist_op OP_UPDATE = 2'd2;

    // Command from the sequencer to the histogram unit.
    typedef struct packed {
        logic     start;
        t_hist_op op;
        logic     dec;
    } t_hist_ctl;

endpackage

>>> sv/wmsd_hist.sv
module wmsd_hist
    import wmsd_pkg::*;
#(
    parameter int VALUE_BINS = WMSD_VALUE_BINS,
    parameter int WINDOW_MAX = WMSD_WINDOW_MAX
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_hist_ctl                           i_ctl,
    input  logic [$clog2(VALUE_BINS)-1:0]       i_old_bin,
    input  logic [$clog2(VALUE_BINS)-1:0]       i_new_bin,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     i_rank_lo,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     i_rank_hi,
    output logic                                o_done,
    output logic [$clog2(VALUE_BINS)-1:0]       o_lo,
    output logic [$clog2(VALUE_BINS)-1:0]       o_hi
);

    localparam int BW = $clog2(VALUE_BINS);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam logic [BW-1:0] LAST_BIN = BW'(VALUE_BINS - 1);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_CLR  = 3'd1;
    localparam logic [2:0] H_SCAN = 3'd2;
    localparam logic [2:0] H_DRD  = 3'd3;
    localparam logic [2:0] H_DWR  = 3'd4;
    localparam logic [2:0] H_IRD  = 3'd5;
    localparam logic [2:0] H_IWR  = 3'd6;

    logic [2:0]    r_state;
    logic [BW-1:0] r_scan;
    logic          r_issue;
    logic          r_dv;
    logic [BW-1:0] r_dbin;
    logic [CW-1:0] r_sum;
    logic          r_lo_found;
    logic [BW-1:0] r_lo;
    logic [BW-1:0] r_hi;
    logic [BW-1:0] r_old;
    logic [BW-1:0] r_new;
    logic          r_done;

    logic [CW-1:0] r_bins [VALUE_BINS];
    logic [CW-1:0] r_q;

    logic          w_rd_en;
    logic [BW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [BW-1:0] w_wr_addr;
    logic [CW-1:0] w_wr_data;
    logic [CW-1:0] w_sum;
    logic          w_hit_lo;
    logic          w_hit_hi;
    logic          w_last;

    assign w_sum    = r_sum + r_q;
    assign w_hit_lo = (w_sum >= i_rank_lo);
    assign w_hit_hi = (w_sum >= i_rank_hi);
    assign w_last   = (r_dbin == LAST_BIN);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_scan;
        w_wr_en   = 1'b0;
        w_wr_addr = r_scan;
        w_wr_data = '0;
        case (r_state)
            H_CLR: begin
                w_wr_en = 1'b1;
            end
            H_SCAN: begin
                w_rd_en = r_issue;
            end
            H_DRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_old;
            end
            H_DWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_old;
                w_wr_data = (r_q == '0) ? '0 : r_q - 1'b1;
            end
            H_IRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_new;
            end
            H_IWR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_new;
                w_wr_data = r_q + 1'b1;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_bins[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_q <= r_bins[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= H_CLR;
            r_scan     <= '0;
            r_issue    <= 1'b0;
            r_dv       <= 1'b0;
            r_lo_found <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    r_issue <= 1'b0;
                end
                H_CLR: begin
                    if (r_scan == LAST_BIN) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                H_SCAN: begin
                    // Reads run one bin ahead of the running sum.
                    r_dv   <= r_issue;
                    r_dbin <= r_scan;
                    if (r_issue) begin
                        if (r_scan == LAST_BIN) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_scan <= r_scan + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        r_sum <= w_sum;
                        if (!r_lo_found && (w_hit_lo || w_last)) begin
                            r_lo_found <= 1'b1;
                            r_lo       <= w_hit_lo ? r_dbin : LAST_BIN;
                        end
                        if (w_hit_hi || w_last) begin
                            r_hi    <= w_hit_hi ? r_dbin : LAST_BIN;
                            r_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end
                    end
                end
                H_DRD: begin
                    r_state <= H_DWR;
                end
                H_DWR: begin
                    r_state <= H_IRD;
                end
                H_IRD: begin
                    r_state <= H_IWR;
                end
                H_IWR: begin
                    r_done  <= 1'b1;
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase

            if (i_ctl.start) begin
                case (i_ctl.op)
                    OP_CLEAR: begin
                        r_scan  <= '0;
                        r_state <= H_CLR;
                    end
                    OP_SCAN: begin
                        r_scan     <= '0;
                        r_issue    <= 1'b1;
                        r_dv       <= 1'b0;
                        r_sum      <= '0;
                        r_lo_found <= 1'b0;
                        r_state    <= H_SCAN;
                    end
                    OP_UPDATE: begin
                        r_old   <= i_old_bin;
                        r_new   <= i_new_bin;
                        r_state <= i_ctl.dec ? H_DRD : H_IRD;
                    end
                    default: begin
                        r_state <= H_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;

endmodule

>>> sv/windowed_median_spike_detector_top.sv
// Sliding-window median spike detector. Each input beat carries one 8-bit sample;
// each produces exactly one output beat. Until window_length samples are held a
// sample is only stored (window_full = 0). Once the window is full the histogram
// of the window is walked bin by bin through its one read port to find the
// median; the walk stops early at the bin holding the upper middle value. No new
// sample is taken until the one before has finished its work. notify is raised
// when the sample is at least twice the median, and notify_count saturates. A
// result that is not taken stalls the next item only once that item has finished
// its own work. After reset and after every write of window_length the histogram
// is cleared, one bin a cycle, and no input beat is taken until that is done;
// the write also restarts filling.
module windowed_median_spike_detector_top
    import wmsd_pkg::*;
#(
    parameter int VALUE_BINS = WMSD_VALUE_BINS,
    parameter int WINDOW_MAX = WMSD_WINDOW_MAX
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,  // window_length
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,      // [7:0] expense_value
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata       // [0] window_full, [1] notify,
                                                   // [33:2] notify_count, rest zero
);

    localparam int BW = $clog2(VALUE_BINS);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            r_state;
    logic [CFG_W-1:0]      r_wlen;
    logic [CW-1:0]         r_fill;
    logic [AW-1:0]         r_wptr;
    logic [CNT_W-1:0]      r_total;
    logic [BW-1:0]         r_v;
    logic                  r_full;
    logic                  r_notify;
    logic                  r_out_valid;
    logic                  r_out_full;
    logic                  r_out_notify;
    logic [CNT_W-1:0]      r_out_total;

    logic [IN_TDATA_W-1:0] r_ring [WINDOW_MAX];
    logic [IN_TDATA_W-1:0] r_ring_q;

    logic                  w_accept;
    logic [CW-1:0]         w_len;
    logic [CW-1:0]         w_rank_lo;
    logic [CW-1:0]         w_rank_hi;
    logic [AW-1:0]         w_slot;
    logic [AW-1:0]         w_wptr_next;
    logic                  w_full;
    logic [BW-1:0]         w_v;
    logic [BW-1:0]         w_old;
    logic [BW-1:0]         w_new_bin;
    logic [BW-1:0]         w_lo;
    logic [BW-1:0]         w_hi;
    logic                  w_flag;
    logic                  w_hist_done;
    t_hist_ctl             w_ctl;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Effective window length: zero acts as one, and it is capped at the ring size.
    always_comb begin
        if (r_wlen == '0) begin
            w_len = CW'(1);
        end else if (32'(r_wlen) > WINDOW_MAX) begin
            w_len = CW'(WINDOW_MAX);
        end else begin
            w_len = CW'(r_wlen);
        end
    end

    assign w_rank_lo = CW'(({1'b0, w_len} + 1'b1) >> 1);
    assign w_rank_hi = CW'(({1'b0, w_len} >> 1) + 1'b1);

    assign w_slot      = (32'(r_wptr) >= 32'(w_len)) ? '0 : r_wptr;
    assign w_wptr_next = (32'(w_slot) + 1 >= 32'(w_len)) ? '0 : AW'(32'(w_slot) + 1);
    assign w_full      = (r_fill >= w_len);

    always_comb begin
        if (32'(i_s_tdata) >= VALUE_BINS) begin
            w_v = BW'(VALUE_BINS - 1);
        end else begin
            w_v = BW'(i_s_tdata);
        end
        if (32'(r_ring_q) >= VALUE_BINS) begin
            w_old = BW'(VALUE_BINS - 1);
        end else begin
            w_old = BW'(r_ring_q);
        end
    end

    assign w_new_bin = w_accept ? w_v : r_v;

    // Twice the median is compared as the sum of the two middle values.
    assign w_flag = ({1'b0, r_v} >= ({1'b0, w_lo} + {1'b0, w_hi}));

    always_comb begin
        w_ctl = '0;
        if (i_cfg_wr_en) begin
            w_ctl.start = 1'b1;
            w_ctl.op    = OP_CLEAR;
        end else if (w_accept) begin
            w_ctl.start = 1'b1;
            w_ctl.op    = w_full ? OP_SCAN : OP_UPDATE;
        end else if (r_state == S_SCAN && w_hist_done) begin
            w_ctl.start = 1'b1;
            w_ctl.op    = OP_UPDATE;
            w_ctl.dec   = 1'b1;
        end
    end

    wmsd_hist #(
        .VALUE_BINS (VALUE_BINS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_old_bin (w_old),
        .i_new_bin (w_new_bin),
        .i_rank_lo (w_rank_lo),
        .i_rank_hi (w_rank_hi),
        .o_done    (w_hist_done),
        .o_lo      (w_lo),
        .o_hi      (w_hi)
    );

    // The oldest sample is read out in the same beat as the new one replaces it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring_q       <= r_ring[w_slot];
            r_ring[w_slot] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_wlen      <= CFG_W'(1);
            r_fill      <= '0;
            r_wptr      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (w_hist_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_v      <= w_v;
                        r_full   <= w_full;
                        r_notify <= 1'b0;
                        r_wptr   <= w_wptr_next;
                        if (!w_full) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= w_full ? S_SCAN : S_UPD;
                    end
                end
                S_SCAN: begin
                    if (w_hist_done) begin
                        if (w_flag) begin
                            r_notify <= 1'b1;
                            if (r_total != '1) begin
                                r_total <= r_total + 1'b1;
                            end
                        end
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_hist_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_full   <= r_full;
                        r_out_notify <= r_notify;
                        r_out_total  <= r_total;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_wr_en) begin
                r_wlen  <= i_cfg_wr_data;
                r_fill  <= '0;
                r_wptr  <= '0;
                r_state <= S_CLR;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), r_out_total, r_out_notify, r_out_full};

endmodule

>>> sv/wmsd_checker.sv
module wmsd_checker
    import wmsd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_wr_en,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    // The histogram is being cleared in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("input taken straight after reset");

    // Each sample is worked on alone.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("second beat taken while one is at work");

    // A window_length write starts a clearing pass.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !i_s_tready)
        else $error("input taken during clearing pass");

    // No notification without a median test.
    a_notify_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[0] || !i_m_tdata[1]))
        else $error("notify set while window not full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind windowed_median_spike_detector_top wmsd_checker u_wmsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_s_tvalid  (i_s_tvalid),
    .i_s_tready  (o_s_tready),
    .i_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .i_m_tdata   (o_m_tdata)
);

>>> tb/spike_result_monitor.sv
module spike_result_monitor
    import wmsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int unsigned            o_fail_count,
    output int unsigned            o_results_seen,
    output int unsigned            o_awaiting,
    output int unsigned            o_spikes_seen
);

    typedef struct packed {
        logic             full;
        logic             notify;
        logic [CNT_W-1:0] total;
    } t_spike_outcome;

    t_spike_outcome awaited_outcomes[$];

    logic [10:0]      bin_tally [WMSD_VALUE_BINS];
    logic [7:0]       sample_ring [WMSD_WINDOW_MAX];
    int unsigned      ring_slot;
    int unsigned      held_count;
    logic [CFG_W-1:0] length_reg;
    logic [CNT_W-1:0] spike_total;

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned spikes_seen  = 0;

    function automatic void restart_window();
        for (int b = 0; b < WMSD_VALUE_BINS; b++) begin
            bin_tally[b] = '0;
        end
        ring_slot  = 0;
        held_count = 0;
    endfunction

    function automatic void enqueue_outcome(t_spike_outcome outcome);
        awaited_outcomes = {awaited_outcomes, outcome};
    endfunction

    // Lowest bin at which the running count of the histogram reaches the rank.
    function automatic int unsigned bin_reaching(int unsigned rank);
        int unsigned sum;
        sum = 0;
        for (int b = 0; b < WMSD_VALUE_BINS; b++) begin
            sum += bin_tally[b];
            if (sum >= rank) begin
                return b;
            end
        end
        return WMSD_VALUE_BINS - 1;
    endfunction

    function automatic t_spike_outcome predict_outcome(logic [7:0] smp);
        t_spike_outcome res;
        int unsigned    span;
        int unsigned    slot;
        int unsigned    lo;
        int unsigned    hi;
        res = '0;
        if (length_reg == 0) begin
            span = 1;
        end else if (length_reg > WMSD_WINDOW_MAX) begin
            span = WMSD_WINDOW_MAX;
        end else begin
            span = length_reg;
        end
        if (ring_slot >= span) begin
            ring_slot = 0;
        end
        slot = ring_slot;
        if (held_count >= span) begin
            // For an even window, whose middle values may share a bin, twice the
            // median is simply the sum of both middle values.
            lo = bin_reaching((span + 1) / 2);
            hi = bin_reaching(span / 2 + 1);
            res.full = 1'b1;
            if (smp >= lo + hi) begin
                res.notify = 1'b1;
                if (spike_total != '1) begin
                    spike_total++;
                end
            end
            if (bin_tally[sample_ring[slot]] != 0) begin
                bin_tally[sample_ring[slot]]--;
            end
        end else begin
            held_count++;
        end
        sample_ring[slot] = smp;
        bin_tally[smp]++;
        ring_slot = (slot + 1 >= span) ? 0 : slot + 1;
        res.total = spike_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_spike_outcome want;
        if (!i_rst_n) begin
            length_reg  = 11'd1;
            spike_total = '0;
            restart_window();
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                length_reg = i_cfg_wr_data;
                restart_window();
            end
            if (i_s_tvalid && i_s_tready) begin
                enqueue_outcome(predict_outcome(i_s_tdata[7:0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (i_m_tdata[1] === 1'b1) begin
                    spikes_seen++;
                end
                if (awaited_outcomes.size() == 0) begin
                    $error("result beat %h arrived with no sample waiting", i_m_tdata);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (i_m_tdata[0] !== want.full) begin
                        $error("window_full: expected %0d, got %0d", want.full, i_m_tdata[0]);
                        mismatches++;
                    end
                    if (i_m_tdata[1] !== want.notify) begin
                        $error("notify: expected %0d, got %0d", want.notify, i_m_tdata[1]);
                        mismatches++;
                    end
                    if (i_m_tdata[2 +: CNT_W] !== want.total) begin
                        $error("notify_count: expected %0d, got %0d",
                               want.total, i_m_tdata[2 +: CNT_W]);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count   <= mismatches;
        o_results_seen <= results_seen;
        o_awaiting     <= awaited_outcomes.size();
        o_spikes_seen  <= spikes_seen;
    end

endmodule

>>> tb/windowed_median_spike_detector_top_tb.sv
module windowed_median_spike_detector_top_tb;
    import wmsd_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned fail_count;
    int unsigned results_seen;
    int unsigned awaiting;
    int unsigned spikes_seen;

    int unsigned sent_count = 0;
    int unsigned length_writes = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    windowed_median_spike_detector_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata)
    );

    spike_result_monitor u_spike_monitor (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen),
        .o_awaiting     (awaiting),
        .o_spikes_seen  (spikes_seen)
    );

    // Result side: a random stall before each beat, and one long hold-off on request
    // so that the block backs up and stops taking samples.
    initial begin
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (hold_req && !hold_done) begin
                gap       = 400;
                hold_done = 1'b1;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_sample(input logic [7:0] smp);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic wait_drained();
        while (results_seen < sent_count) @(posedge clk);
    endtask

    // The length may only change once the block has returned every result.
    task automatic write_length(input logic [CFG_W-1:0] len);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        length_writes++;
    endtask

    // Mostly values near a baseline, some near twice it, the rest anywhere.
    function automatic logic [7:0] draw_sample(int unsigned level);
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            v = level + $urandom_range(0, 20);
        end else if (pick < 85) begin
            v = 2 * level + $urandom_range(0, 40);
        end else begin
            v = $urandom_range(0, 255);
        end
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    initial begin
        int unsigned random_sent;
        int unsigned phase_no;
        int unsigned span;
        int unsigned level;
        int unsigned n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Length 1 from reset: a zero median flags anything, and twice the
        // median is met exactly by 254 against 127.
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd127);
        send_sample(8'd254);
        send_sample(8'd253);

        // A length of zero behaves as one.
        write_length(11'd0);
        send_sample(8'd10);
        send_sample(8'd20);
        send_sample(8'd19);

        // Even window 10,10,30,30: the middle pair is 10 and 30, so 40 just flags.
        write_length(11'd4);
        send_sample(8'd10);
        send_sample(8'd10);
        send_sample(8'd30);
        send_sample(8'd30);
        send_sample(8'd40);
        send_sample(8'd39);

        write_length(11'd3);
        send_sample(8'd5);
        send_sample(8'd5);
        send_sample(8'd9);
        send_sample(8'd10);
        send_sample(8'd9);

        random_sent = 0;
        phase_no    = 0;
        while (random_sent < 520) begin
            span = (phase_no % 4 == 3) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            write_length(span[CFG_W-1:0]);
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase_no == 1) begin
                hold_req = 1'b1;
            end
            level = $urandom_range(0, 90);
            n     = span + $urandom_range(15, 50);
            for (int k = 0; k < n; k++) begin
                send_sample(draw_sample(level));
            end
            random_sent += n;
            phase_no++;
        end

        // A length beyond the largest window is held at the largest window, so
        // these samples only fill it.
        write_length(11'd2047);
        no_idle = 1'b0;
        level   = $urandom_range(0, 90);
        for (int k = 0; k < 60; k++) begin
            send_sample(draw_sample(level));
        end

        write_length(11'd1024);
        for (int k = 0; k < 20; k++) begin
            send_sample(draw_sample(level));
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);

        $display("Sent %0d samples over %0d length settings, from zero up to beyond the limit.",
                 sent_count, length_writes);
        $display("Checked %0d results, %0d of them flagged as spikes.",
                 results_seen, spikes_seen);
        if (fail_count == 0 && awaiting == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
